FILE: rtl/fft2_pkg.sv
// Shared types and constants for the radix-2 FFT butterfly stage core.
// Used by the top level, the complex multiplier, and the port checker.
// No dependencies.
package fft2_pkg;

    // Default values for the top-level parameters.
    localparam int MAX_POINTS_DEF   = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths of the stream payloads.
    localparam int INDEX_W   = 10;
    localparam int FIELD_W   = 16;
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // Bit offsets inside tdata (same layout on both sides).
    localparam int IDX_LSB  = 0;
    localparam int REAL_LSB = INDEX_W;
    localparam int IMAG_LSB = INDEX_W + FIELD_W;

    // Configuration register widths and the write port.
    localparam int COUNT_W    = 11;
    localparam int HALF_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Loop counter width: i stays below the point count (at most 2047) before a
    // span of at most 2047 is added, so twelve bits always suffice.
    localparam int CNT_W = 12;

    // Q1.15 arithmetic.
    localparam int Q_SHIFT = 15;
    localparam int TW_MAX  = 32767;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_SPAN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SPAN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0]           POINT_COUNT_RST = 11'd1024;
    localparam logic [COUNT_W-1:0]           STAGE_SPAN_RST  = 11'd2;
    localparam logic [HALF_W-1:0]            HALF_SPAN_RST   = 10'd1;
    localparam logic signed [FIELD_W-1:0]    STEP_REAL_RST   = -16'sd32768;
    localparam logic signed [FIELD_W-1:0]    STEP_IMAG_RST   = 16'sd0;

    // Unity twiddle is held as the largest Q1.15 value.
    localparam logic signed [FIELD_W-1:0]    TW_ONE = 16'sd32767;

    // Input action codes carried on s_tuser.
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

endpackage

FILE: rtl/fft2_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Used for the point store of the FFT butterfly stage core. No dependencies.
module fft2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, and a read port whose data holds until the next read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fft2_cmul.sv
// Iterative complex multiplier with Q1.15 rounding: one shared multiplier,
// four partial products formed in turn. Depends on fft2_pkg.
module fft2_cmul import fft2_pkg::*; #(
    parameter int XW = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [XW-1:0]      x_re,
    input  logic signed [XW-1:0]      x_im,
    input  logic signed [FIELD_W-1:0] y_re,
    input  logic signed [FIELD_W-1:0] y_im,
    output logic                      done,
    output logic signed [XW+2:0]      re_out,
    output logic signed [XW+2:0]      im_out
);

    localparam int PW   = XW + FIELD_W;
    localparam int ACCW = PW + 2;
    localparam logic signed [ACCW-1:0] HALF = ACCW'(1) <<< (Q_SHIFT - 1);

    typedef enum logic [2:0] {
        CM_IDLE,
        CM_P0,
        CM_P1,
        CM_P2,
        CM_P3,
        CM_ACC
    } cm_state_t;

    cm_state_t                state_reg, state_next;
    logic                     done_reg, done_next;
    logic signed [XW-1:0]     xr_reg, xi_reg;
    logic signed [FIELD_W-1:0] yr_reg, yi_reg;
    logic signed [PW-1:0]     prod_reg, prod_next;
    logic signed [ACCW-1:0]   acc_re_reg, acc_re_next;
    logic signed [ACCW-1:0]   acc_im_reg, acc_im_next;
    logic signed [XW-1:0]     x_sel;
    logic signed [FIELD_W-1:0] y_sel;
    logic signed [ACCW-1:0]   prod_ext;

    // Operand selection for the shared multiplier.
    assign x_sel    = (state_reg == CM_P0 || state_reg == CM_P2) ? xr_reg : xi_reg;
    assign y_sel    = (state_reg == CM_P0 || state_reg == CM_P3) ? yr_reg : yi_reg;
    assign prod_ext = ACCW'(prod_reg);

    // Sequencer: form a product, accumulate it in the next cycle.
    always_comb begin
        state_next  = state_reg;
        done_next   = 1'b0;
        prod_next   = prod_reg;
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        case (state_reg)
            CM_IDLE: begin
                if (start) begin
                    state_next = CM_P0;
                end
            end
            CM_P0: begin
                prod_next  = x_sel * y_sel;
                state_next = CM_P1;
            end
            CM_P1: begin
                prod_next   = x_sel * y_sel;
                acc_re_next = prod_ext + HALF;
                state_next  = CM_P2;
            end
            CM_P2: begin
                prod_next   = x_sel * y_sel;
                acc_re_next = acc_re_reg - prod_ext;
                state_next  = CM_P3;
            end
            CM_P3: begin
                prod_next   = x_sel * y_sel;
                acc_im_next = prod_ext + HALF;
                state_next  = CM_ACC;
            end
            CM_ACC: begin
                acc_im_next = acc_im_reg + prod_ext;
                done_next   = 1'b1;
                state_next  = CM_IDLE;
            end
            default: begin
                state_next = CM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CM_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        prod_reg   <= prod_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        if (state_reg == CM_IDLE && start) begin
            xr_reg <= x_re;
            xi_reg <= x_im;
            yr_reg <= y_re;
            yi_reg <= y_im;
        end
    end

    // The rounding half is already in the sums; the floor is a plain shift.
    assign done   = done_reg;
    assign re_out = acc_re_reg[ACCW-1:Q_SHIFT];
    assign im_out = acc_im_reg[ACCW-1:Q_SHIFT];

endmodule

FILE: rtl/fft_radix2_butterfly_stage_core.sv
// Radix-2 decimation-in-time FFT stage over a stored array of complex points.
// Depends on fft2_pkg, fft2_ram (point store) and fft2_cmul (twiddle products).
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  tdata: index, real_in, imag_in; tuser: action
//   m_*       out        m_tvalid/m_tready  tdata: index_out, real_out, imag_out
//   cfg_*     in         cfg_wr_en          cfg_index, cfg_wdata
//
// Point writes and reads are each taken in one transfer; a read result passes the
// point store's registered read port on its way to the output register.
// A run stalls the input until the stage is done: the one shared multiplier
// builds each complex product from four partial products.
// The store needs no clearing after reset.
// Reset is synchronous and active low; a stalled result holds its register.
module fft_radix2_butterfly_stage_core import fft2_pkg::*; #(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Fields from bit 0: index[9:0], real_in[25:10], imag_in[41:26], zero fill.
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: index_out[9:0], real_out[25:10], imag_out[41:26], zero fill.
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SW   = SAMPLE_WIDTH;
    localparam int XW   = (SW > FIELD_W) ? SW : FIELD_W;
    localparam int TW   = XW + 3;
    localparam int SUMW = TW + 1;
    localparam int MEMW = 2 * SW;

    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [TW-1:0]   TWS_HI = TW'(TW_MAX);
    localparam logic signed [TW-1:0]   TWS_LO = ~TWS_HI;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD_P,
        S_RD_I,
        S_BF_WAIT,
        S_WR_P,
        S_WR_I,
        S_TW_WAIT
    } state_t;

    // Saturate a widened sum to the stored sample width.
    function automatic logic signed [SW-1:0] sat_sample(input logic signed [SUMW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SW-1:0];
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // Saturate a rounded twiddle product to Q1.15.
    function automatic logic signed [FIELD_W-1:0] sat_tw(input logic signed [TW-1:0] v);
        logic signed [FIELD_W-1:0] r;
        if (v > TWS_HI) begin
            r = TWS_HI[FIELD_W-1:0];
        end else if (v < TWS_LO) begin
            r = TWS_LO[FIELD_W-1:0];
        end else begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

    // Input payload fields.
    logic [INDEX_W-1:0]          s_index;
    logic signed [FIELD_W-1:0]   s_real, s_imag;
    action_t                     s_action;
    logic                        s_fire;
    logic                        in_range;

    // Configuration registers.
    logic [COUNT_W-1:0]          point_count_reg;
    logic [COUNT_W-1:0]          stage_span_reg;
    logic [HALF_W-1:0]           half_span_reg;
    logic signed [FIELD_W-1:0]   step_re_reg, step_im_reg;

    // Stage walk state.
    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            i_reg, i_next;
    logic [HALF_W-1:0]           j_reg, j_next;
    logic [COUNT_W-1:0]          n_reg, n_next;
    logic signed [FIELD_W-1:0]   tw_re_reg, tw_re_next, tw_im_reg, tw_im_next;
    logic [CNT_W-1:0]            p_idx;
    logic                        i_lt_n, p_lt_n;
    logic [HALF_W:0]             j_inc;

    // Read result path.
    logic                        pend_valid_reg, pend_valid_next;
    logic [INDEX_W-1:0]          pend_index_reg, pend_index_next;
    logic                        pend_zero_reg, pend_zero_next;
    logic                        m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]          m_index_reg, m_index_next;
    logic [FIELD_W-1:0]          m_re_reg, m_re_next, m_im_reg, m_im_next;
    logic                        out_free, pend_move;

    // Point store ports.
    logic                        ram_wr_en, ram_rd_en;
    logic [AW-1:0]               ram_wr_addr, ram_rd_addr;
    logic [MEMW-1:0]             ram_wr_data, ram_rd_data;
    logic signed [SW-1:0]        rd_re, rd_im;

    // Complex multiplier.
    logic                        cm_start, cm_done;
    logic signed [XW-1:0]        cm_x_re, cm_x_im;
    logic signed [FIELD_W-1:0]   cm_y_re, cm_y_im;
    logic signed [TW-1:0]        cm_re, cm_im;

    // Butterfly outputs.
    logic signed [SUMW-1:0]      sum_re, sum_im, diff_re, diff_im;

    assign s_index  = s_tdata[IDX_LSB +: INDEX_W];
    assign s_real   = s_tdata[REAL_LSB +: FIELD_W];
    assign s_imag   = s_tdata[IMAG_LSB +: FIELD_W];
    assign s_action = action_t'(s_tuser[1:0]);
    assign s_fire   = s_tvalid && s_tready;
    assign in_range = (32'(s_index) < MAX_POINTS);

    assign rd_re = ram_rd_data[SW-1:0];
    assign rd_im = ram_rd_data[MEMW-1:SW];

    assign p_idx  = i_reg + CNT_W'(half_span_reg);
    assign i_lt_n = (i_reg < CNT_W'(n_reg));
    assign p_lt_n = (p_idx < CNT_W'(n_reg));
    assign j_inc  = {1'b0, j_reg} + 1'b1;

    assign sum_re  = SUMW'(rd_re) + SUMW'(cm_re);
    assign sum_im  = SUMW'(rd_im) + SUMW'(cm_im);
    assign diff_re = SUMW'(rd_re) - SUMW'(cm_re);
    assign diff_im = SUMW'(rd_im) - SUMW'(cm_im);

    // Output register frees up when empty or when its transfer completes.
    assign out_free  = !m_valid_reg || m_tready;
    assign pend_move = pend_valid_reg && out_free;
    assign s_tready  = (state_reg == S_IDLE) && (!pend_valid_reg || out_free);

    // The multiplier takes the partner point during a butterfly, else the twiddle.
    assign cm_start = (state_reg == S_RD_I) || (state_reg == S_CHECK && !i_lt_n);
    assign cm_x_re  = (state_reg == S_RD_I) ? XW'(rd_re) : XW'(tw_re_reg);
    assign cm_x_im  = (state_reg == S_RD_I) ? XW'(rd_im) : XW'(tw_im_reg);
    assign cm_y_re  = (state_reg == S_RD_I) ? tw_re_reg : step_re_reg;
    assign cm_y_im  = (state_reg == S_RD_I) ? tw_im_reg : step_im_reg;

    fft2_cmul #(
        .XW (XW)
    ) u_cmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cm_start),
        .x_re    (cm_x_re),
        .x_im    (cm_x_im),
        .y_re    (cm_y_re),
        .y_im    (cm_y_im),
        .done    (cm_done),
        .re_out  (cm_re),
        .im_out  (cm_im)
    );

    fft2_ram #(
        .WIDTH (MEMW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= POINT_COUNT_RST;
            stage_span_reg  <= STAGE_SPAN_RST;
            half_span_reg   <= HALF_SPAN_RST;
            step_re_reg     <= STEP_REAL_RST;
            step_im_reg     <= STEP_IMAG_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POINT_COUNT: point_count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_STAGE_SPAN:  stage_span_reg  <= cfg_wdata[COUNT_W-1:0];
                REG_HALF_SPAN:   half_span_reg   <= cfg_wdata[HALF_W-1:0];
                REG_STEP_REAL:   step_re_reg     <= cfg_wdata;
                REG_STEP_IMAG:   step_im_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Transfers, stage walk and store port control.
    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        tw_re_next      = tw_re_reg;
        tw_im_next      = tw_im_reg;
        pend_valid_next = pend_valid_reg;
        pend_index_next = pend_index_reg;
        pend_zero_next  = pend_zero_reg;
        m_valid_next    = m_valid_reg;
        m_index_next    = m_index_reg;
        m_re_next       = m_re_reg;
        m_im_next       = m_im_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;

        // A pending read moves into the output register as soon as it is free.
        if (pend_move) begin
            pend_valid_next = 1'b0;
            m_valid_next    = 1'b1;
            m_index_next    = pend_index_reg;
            m_re_next       = pend_zero_reg ? '0 : FIELD_W'(rd_re);
            m_im_next       = pend_zero_reg ? '0 : FIELD_W'(rd_im);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_action)
                        ACT_WRITE: begin
                            ram_wr_en   = in_range;
                            ram_wr_addr = AW'(s_index);
                            ram_wr_data = {sat_sample(SUMW'(s_imag)),
                                           sat_sample(SUMW'(s_real))};
                        end
                        ACT_RUN: begin
                            tw_re_next = TW_ONE;
                            tw_im_next = '0;
                            n_next     = (32'(point_count_reg) > MAX_POINTS) ?
                                         COUNT_W'(MAX_POINTS) : point_count_reg;
                            i_next     = '0;
                            j_next     = '0;
                            if (stage_span_reg != '0 && half_span_reg != '0) begin
                                state_next = S_CHECK;
                            end
                        end
                        ACT_READ: begin
                            ram_rd_en       = in_range;
                            ram_rd_addr     = AW'(s_index);
                            pend_valid_next = 1'b1;
                            pend_index_next = s_index;
                            pend_zero_next  = !in_range;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                // Next butterfly (skipped if p >= n), or advance the twiddle.
                if (i_lt_n) begin
                    if (p_lt_n) begin
                        state_next = S_RD_P;
                    end else begin
                        i_next = i_reg + CNT_W'(stage_span_reg);
                    end
                end else begin
                    state_next = S_TW_WAIT;
                end
            end
            S_RD_P: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(p_idx);
                state_next  = S_RD_I;
            end
            S_RD_I: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(i_reg);
                state_next  = S_BF_WAIT;
            end
            S_BF_WAIT: begin
                if (cm_done) begin
                    state_next = S_WR_P;
                end
            end
            S_WR_P: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(p_idx);
                ram_wr_data = {sat_sample(diff_im), sat_sample(diff_re)};
                state_next  = S_WR_I;
            end
            S_WR_I: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(i_reg);
                ram_wr_data = {sat_sample(sum_im), sat_sample(sum_re)};
                i_next      = i_reg + CNT_W'(stage_span_reg);
                state_next  = S_CHECK;
            end
            S_TW_WAIT: begin
                if (cm_done) begin
                    tw_re_next = sat_tw(cm_re);
                    tw_im_next = sat_tw(cm_im);
                    if (j_inc < {1'b0, half_span_reg}) begin
                        j_next     = j_inc[HALF_W-1:0];
                        i_next     = CNT_W'(j_inc);
                        state_next = S_CHECK;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        i_reg          <= i_next;
        j_reg          <= j_next;
        n_reg          <= n_next;
        tw_re_reg      <= tw_re_next;
        tw_im_reg      <= tw_im_next;
        pend_index_reg <= pend_index_next;
        pend_zero_reg  <= pend_zero_next;
        m_index_reg    <= m_index_next;
        m_re_reg       <= m_re_next;
        m_im_reg       <= m_im_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - INDEX_W - 2 * FIELD_W)'(0), m_im_reg, m_re_reg, m_index_reg};

endmodule

FILE: rtl/fft2_checker.sv
// Port-level checks for the radix-2 FFT butterfly stage core, with the bind
// that attaches them to the top level. Depends on fft2_pkg.
module fft2_checker import fft2_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready
);

    // The result register is empty after a reset cycle.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result keeps its payload.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A result only appears in answer to a read transfer, behind the store's registered read port.
    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && (s_tuser[1:0] == ACT_READ), 2))
        else $error("result without a read transfer");

    // That result carries the index of the read.
    a_result_index: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |->
            (m_tdata[IDX_LSB +: INDEX_W] == $past(s_tdata[IDX_LSB +: INDEX_W], 2)))
        else $error("result index does not match the read");

endmodule

bind fft_radix2_butterfly_stage_core fft2_checker u_fft2_checker (.*);
